>>> src/hcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg
// shared constants, codes and types of the huffman code builder
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int MAX_SYMBOLS = 64;
	localparam int COUNT_WIDTH = 16;

	localparam int IDX_W    = $clog2(MAX_SYMBOLS);
	localparam int FILL_W   = $clog2(MAX_SYMBOLS + 1);
	localparam int WEIGHT_W = COUNT_WIDTH + IDX_W;

	localparam int SYM_W    = 8;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int CODE_W   = 63;
	localparam int LEN_W    = 6;
	localparam int DIST_W   = 7;

	localparam int IN_W      = 8;
	localparam int OUT_USED  = STATUS_W + CODE_W + LEN_W + DIST_W;
	localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_W - OUT_USED;

	localparam logic [SYM_W-1:0] MARKER_BYTE = 8'h2A;

	typedef enum logic [OP_W-1:0] {
		OP_COUNT  = 2'd0,
		OP_BUILD  = 2'd1,
		OP_ENCODE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_UNKNOWN   = 2'd2,
		ST_NOT_BUILT = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		STP_IDLE,
		STP_DISP,
		STP_CNT_RD,
		STP_CNT_CHK,
		STP_CNT_NEW,
		STP_ENC_RD,
		STP_ENC_CHK,
		STP_ENC_LEAF,
		STP_ENC_UNK,
		STP_SET_NB,
		STP_SRT_P0,
		STP_SRT_P1,
		STP_SRT_RD,
		STP_SRT_CMP,
		STP_SRT_LAST,
		STP_INI_RD,
		STP_INI_WR,
		STP_MRG_ST,
		STP_MRG_RD,
		STP_MRG_CHK,
		STP_LF_RD,
		STP_LF_WR,
		STP_SUM_WR,
		STP_SH_RD,
		STP_SH_WR,
		STP_MRG_END,
		STP_BLD_END,
		STP_EMIT
	} step_t;

	typedef struct packed {
		step_t step;
		logic  load;
	} hcb_cmd_t;

	typedef struct packed {
		op_t  op;
		logic is_marker;
		logic fill_zero;
		logic fill_lt2;
		logic ready;
		logic at_end;
		logic match;
		logic cmp_last;
		logic pass_last;
		logic last_entry;
		logic live_one;
		logic scan_last;
		logic sh_none;
		logic sh_last;
		logic out_free;
	} hcb_stat_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] cnt;
		logic [SYM_W-1:0]       sym;
	} tab_ent_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [IDX_W-1:0]  slot;
	} leaf_ent_t;

	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [DIST_W-1:0]    distinct_symbols;
		logic [LEN_W-1:0]     code_length;
		logic [CODE_W-1:0]    code_bits;
		status_t              status;
	} out_pkt_t;

endpackage
`default_nettype wire

>>> src/hcb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/hcb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_ctrl
// sequencer of the huffman code builder: walks count, sort, merge and encode
// ----------------------------------------------------------------------------
module hcb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire hcb_pkg::hcb_stat_t stat,
	output hcb_pkg::hcb_cmd_t      cmd
);
	import hcb_pkg::*;

	typedef enum logic [27:0] {
		S_IDLE     = 28'h0000001,
		S_DISP     = 28'h0000002,
		S_CNT_RD   = 28'h0000004,
		S_CNT_CHK  = 28'h0000008,
		S_CNT_NEW  = 28'h0000010,
		S_ENC_RD   = 28'h0000020,
		S_ENC_CHK  = 28'h0000040,
		S_ENC_LEAF = 28'h0000080,
		S_ENC_UNK  = 28'h0000100,
		S_SET_NB   = 28'h0000200,
		S_SRT_P0   = 28'h0000400,
		S_SRT_P1   = 28'h0000800,
		S_SRT_RD   = 28'h0001000,
		S_SRT_CMP  = 28'h0002000,
		S_SRT_LAST = 28'h0004000,
		S_INI_RD   = 28'h0008000,
		S_INI_WR   = 28'h0010000,
		S_MRG_ST   = 28'h0020000,
		S_MRG_RD   = 28'h0040000,
		S_MRG_CHK  = 28'h0080000,
		S_LF_RD    = 28'h0100000,
		S_LF_WR    = 28'h0200000,
		S_SUM_WR   = 28'h0400000,
		S_SH_RD    = 28'h0800000,
		S_SH_WR    = 28'h1000000,
		S_MRG_END  = 28'h2000000,
		S_BLD_END  = 28'h4000000,
		S_EMIT     = 28'h8000000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.load = s_tready && s_tvalid;
		cmd.step = STP_IDLE;
		case (state_q)
			S_IDLE: begin
				cmd.step = STP_IDLE;
				if (s_tvalid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.step = STP_DISP;
				case (stat.op)
					OP_COUNT:  state_d = stat.is_marker ? S_EMIT : S_CNT_RD;
					OP_BUILD: begin
						if (stat.fill_zero) begin
							state_d = S_SET_NB;
						end else if (stat.fill_lt2) begin
							state_d = S_INI_RD;
						end else begin
							state_d = S_SRT_P0;
						end
					end
					OP_ENCODE: state_d = stat.ready ? S_ENC_RD : S_SET_NB;
					default:   state_d = S_EMIT;
				endcase
			end
			S_CNT_RD: begin
				cmd.step = STP_CNT_RD;
				state_d  = stat.at_end ? S_CNT_NEW : S_CNT_CHK;
			end
			S_CNT_CHK: begin
				cmd.step = STP_CNT_CHK;
				state_d  = stat.match ? S_EMIT : S_CNT_RD;
			end
			S_CNT_NEW: begin
				cmd.step = STP_CNT_NEW;
				state_d  = S_EMIT;
			end
			S_ENC_RD: begin
				cmd.step = STP_ENC_RD;
				state_d  = stat.at_end ? S_ENC_UNK : S_ENC_CHK;
			end
			S_ENC_CHK: begin
				cmd.step = STP_ENC_CHK;
				state_d  = stat.match ? S_ENC_LEAF : S_ENC_RD;
			end
			S_ENC_LEAF: begin
				cmd.step = STP_ENC_LEAF;
				state_d  = S_EMIT;
			end
			S_ENC_UNK: begin
				cmd.step = STP_ENC_UNK;
				state_d  = S_EMIT;
			end
			S_SET_NB: begin
				cmd.step = STP_SET_NB;
				state_d  = S_EMIT;
			end
			S_SRT_P0: begin
				cmd.step = STP_SRT_P0;
				state_d  = S_SRT_P1;
			end
			S_SRT_P1: begin
				cmd.step = STP_SRT_P1;
				state_d  = S_SRT_RD;
			end
			S_SRT_RD: begin
				cmd.step = STP_SRT_RD;
				state_d  = S_SRT_CMP;
			end
			S_SRT_CMP: begin
				cmd.step = STP_SRT_CMP;
				state_d  = stat.cmp_last ? S_SRT_LAST : S_SRT_RD;
			end
			S_SRT_LAST: begin
				cmd.step = STP_SRT_LAST;
				state_d  = stat.pass_last ? S_INI_RD : S_SRT_P0;
			end
			S_INI_RD: begin
				cmd.step = STP_INI_RD;
				state_d  = S_INI_WR;
			end
			S_INI_WR: begin
				cmd.step = STP_INI_WR;
				state_d  = stat.last_entry ? S_MRG_ST : S_INI_RD;
			end
			S_MRG_ST: begin
				cmd.step = STP_MRG_ST;
				state_d  = stat.live_one ? S_BLD_END : S_MRG_RD;
			end
			S_MRG_RD: begin
				cmd.step = STP_MRG_RD;
				state_d  = S_MRG_CHK;
			end
			S_MRG_CHK: begin
				cmd.step = STP_MRG_CHK;
				state_d  = stat.scan_last ? S_LF_RD : S_MRG_RD;
			end
			S_LF_RD: begin
				cmd.step = STP_LF_RD;
				state_d  = S_LF_WR;
			end
			S_LF_WR: begin
				cmd.step = STP_LF_WR;
				state_d  = stat.last_entry ? S_SUM_WR : S_LF_RD;
			end
			S_SUM_WR: begin
				cmd.step = STP_SUM_WR;
				state_d  = stat.sh_none ? S_MRG_END : S_SH_RD;
			end
			S_SH_RD: begin
				cmd.step = STP_SH_RD;
				state_d  = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.step = STP_SH_WR;
				state_d  = stat.sh_last ? S_MRG_END : S_SH_RD;
			end
			S_MRG_END: begin
				cmd.step = STP_MRG_END;
				state_d  = S_MRG_ST;
			end
			S_BLD_END: begin
				cmd.step = STP_BLD_END;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				cmd.step = STP_EMIT;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				cmd.step = STP_IDLE;
				state_d  = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_emit_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && stat.out_free) |=> (state_q == S_IDLE))
		else $error("result emit did not return to idle");
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DISP))
		else $error("accepted item not dispatched");
	a_merge_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MRG_RD) |-> !stat.live_one)
		else $error("merge scan started with a single node");
`endif

endmodule
`default_nettype wire

>>> src/hcb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_dp
// datapath: symbol table, node weights, leaf codes and result register
// ----------------------------------------------------------------------------
module hcb_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [hcb_pkg::IN_W-1:0]     s_tdata,
	input  wire logic [hcb_pkg::OP_W-1:0]     s_tuser,
	input  wire logic                         m_tready,
	output logic                              m_tvalid,
	output logic      [hcb_pkg::OUT_W-1:0]    m_tdata,
	input  wire hcb_pkg::hcb_cmd_t            cmd,
	output hcb_pkg::hcb_stat_t                stat
);
	import hcb_pkg::*;

	op_t                   op_q;
	logic [SYM_W-1:0]      sym_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  ready_q;
	logic [FILL_W-1:0]     i_q;
	logic [IDX_W-1:0]      pass_q;
	logic [FILL_W-1:0]     live_q;
	logic [IDX_W-1:0]      lo_q, hi_q;
	logic [WEIGHT_W-1:0]   wlo_q, whi_q;
	logic                  have_hi_q;
	tab_ent_t              cur_q;
	status_t               res_status_q;
	logic [CODE_W-1:0]     res_bits_q;
	logic [LEN_W-1:0]      res_len_q;
	out_pkt_t              out_q;
	logic                  m_tvalid_q;

	logic                  tab_we, wgt_we, leaf_we;
	logic [IDX_W-1:0]      tab_waddr, tab_raddr, wgt_waddr, wgt_raddr, leaf_waddr, leaf_raddr;
	tab_ent_t              tab_wdata, tab_rd;
	logic [WEIGHT_W-1:0]   wgt_wdata, wgt_rd;
	leaf_ent_t             leaf_wdata, leaf_rd, leaf_upd;

	logic [IDX_W-1:0]      i_idx, i_inc_idx;
	logic [FILL_W-1:0]     i_inc;
	logic                  full, swap, out_free;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic                  leaf_hit;
	logic [IDX_W-1:0]      slot_mid;

	assign i_idx     = i_q[IDX_W-1:0];
	assign i_inc     = i_q + FILL_W'(1);
	assign i_inc_idx = i_inc[IDX_W-1:0];
	assign full      = (fill_q == FILL_W'(MAX_SYMBOLS));
	assign swap      = (cur_q.cnt < tab_rd.cnt);
	assign cnt_inc   = (&tab_rd.cnt) ? tab_rd.cnt : tab_rd.cnt + COUNT_WIDTH'(1);
	assign out_free  = !m_tvalid_q || m_tready;

	hcb_ram #(.WIDTH($bits(tab_ent_t)), .DEPTH(MAX_SYMBOLS)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (tab_raddr),
		.rdata (tab_rd)
	);

	hcb_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_SYMBOLS)) u_wgt (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (wgt_wdata),
		.raddr (wgt_raddr),
		.rdata (wgt_rd)
	);

	hcb_ram #(.WIDTH($bits(leaf_ent_t)), .DEPTH(MAX_SYMBOLS)) u_leaf (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.raddr (leaf_raddr),
		.rdata (leaf_rd)
	);

	// one merge step applied to a leaf, then the removed slot closed up
	always_comb begin
		leaf_upd = leaf_rd;
		leaf_hit = (leaf_rd.slot == lo_q) || (leaf_rd.slot == hi_q);
		if (leaf_hit) begin
			if (leaf_rd.slot == hi_q) begin
				leaf_upd.code = leaf_rd.code | (CODE_W'(1) << leaf_rd.len);
			end
			leaf_upd.len = leaf_rd.len + LEN_W'(1);
		end
		slot_mid = leaf_hit ? lo_q : leaf_rd.slot;
		leaf_upd.slot = (slot_mid > hi_q) ? slot_mid - IDX_W'(1) : slot_mid;
	end

	always_comb begin
		tab_we     = 1'b0;
		tab_waddr  = i_idx;
		tab_wdata  = cur_q;
		tab_raddr  = i_idx;
		wgt_we     = 1'b0;
		wgt_waddr  = i_idx;
		wgt_wdata  = wgt_rd;
		wgt_raddr  = i_idx;
		leaf_we    = 1'b0;
		leaf_waddr = i_idx;
		leaf_wdata = leaf_upd;
		leaf_raddr = i_idx;
		case (cmd.step)
			STP_CNT_CHK: begin
				if (stat.match) begin
					tab_we    = 1'b1;
					tab_wdata = '{cnt: cnt_inc, sym: sym_q};
				end
			end
			STP_CNT_NEW: begin
				if (!full) begin
					tab_we    = 1'b1;
					tab_waddr = fill_q[IDX_W-1:0];
					tab_wdata = '{cnt: COUNT_WIDTH'(1), sym: sym_q};
				end
			end
			STP_SRT_P0:  tab_raddr = '0;
			STP_SRT_RD:  tab_raddr = i_inc_idx;
			STP_SRT_CMP: begin
				tab_we    = 1'b1;
				tab_wdata = swap ? tab_rd : cur_q;
			end
			STP_SRT_LAST: tab_we = 1'b1;
			STP_INI_WR: begin
				wgt_we     = 1'b1;
				wgt_wdata  = WEIGHT_W'(tab_rd.cnt);
				leaf_we    = 1'b1;
				leaf_wdata = '{code: '0, len: '0, slot: i_idx};
			end
			STP_LF_WR:  leaf_we = 1'b1;
			STP_SUM_WR: begin
				wgt_we    = 1'b1;
				wgt_waddr = lo_q;
				wgt_wdata = wlo_q + whi_q;
			end
			STP_SH_RD:  wgt_raddr = i_inc_idx;
			STP_SH_WR:  wgt_we = 1'b1;
			default: begin
				tab_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			ready_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			i_q        <= '0;
			pass_q     <= '0;
			live_q     <= '0;
			have_hi_q  <= 1'b0;
		end else begin
			if (cmd.step == STP_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cmd.load) begin
				i_q    <= '0;
				pass_q <= '0;
				live_q <= fill_q;
			end
			case (cmd.step)
				STP_CNT_CHK: begin
					if (stat.match) begin
						ready_q <= 1'b0;
					end else begin
						i_q <= i_inc;
					end
				end
				STP_CNT_NEW: begin
					if (!full) begin
						fill_q  <= fill_q + FILL_W'(1);
						ready_q <= 1'b0;
					end
				end
				STP_ENC_CHK: begin
					if (!stat.match) begin
						i_q <= i_inc;
					end
				end
				STP_SET_NB:  ready_q <= 1'b0;
				STP_SRT_P0:  i_q <= '0;
				STP_SRT_CMP: i_q <= i_inc;
				STP_SRT_LAST: begin
					pass_q <= pass_q + IDX_W'(1);
					i_q    <= '0;
				end
				STP_INI_WR: i_q <= i_inc;
				STP_MRG_ST: begin
					i_q       <= '0;
					have_hi_q <= 1'b0;
				end
				STP_MRG_CHK: begin
					i_q <= stat.scan_last ? '0 : i_inc;
					if (i_q != '0 && (wgt_rd < wlo_q || !have_hi_q || wgt_rd < whi_q)) begin
						have_hi_q <= 1'b1;
					end
				end
				STP_LF_WR:   i_q <= i_inc;
				STP_SUM_WR:  i_q <= FILL_W'(hi_q);
				STP_SH_WR:   i_q <= i_inc;
				STP_MRG_END: live_q <= live_q - FILL_W'(1);
				STP_BLD_END: ready_q <= 1'b1;
				default: begin
					ready_q <= ready_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= op_t'(s_tuser);
			sym_q        <= s_tdata[SYM_W-1:0];
			res_status_q <= ST_OK;
			res_bits_q   <= '0;
			res_len_q    <= '0;
		end
		case (cmd.step)
			STP_CNT_NEW: begin
				if (full) begin
					res_status_q <= ST_FULL;
				end
			end
			STP_ENC_LEAF: begin
				res_bits_q <= leaf_rd.code;
				res_len_q  <= leaf_rd.len;
			end
			STP_ENC_UNK: res_status_q <= ST_UNKNOWN;
			STP_SET_NB:  res_status_q <= ST_NOT_BUILT;
			STP_SRT_P1:  cur_q <= tab_rd;
			STP_SRT_CMP: begin
				if (!swap) begin
					cur_q <= tab_rd;
				end
			end
			STP_MRG_CHK: begin
				if (i_q == '0) begin
					lo_q  <= '0;
					wlo_q <= wgt_rd;
				end else if (wgt_rd < wlo_q) begin
					hi_q  <= lo_q;
					whi_q <= wlo_q;
					lo_q  <= i_idx;
					wlo_q <= wgt_rd;
				end else if (!have_hi_q || wgt_rd < whi_q) begin
					hi_q  <= i_idx;
					whi_q <= wgt_rd;
				end
			end
			STP_EMIT: begin
				if (out_free) begin
					out_q.pad              <= '0;
					out_q.distinct_symbols <= DIST_W'(fill_q);
					out_q.code_length      <= res_len_q;
					out_q.code_bits        <= res_bits_q;
					out_q.status           <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	assign stat.op         = op_q;
	assign stat.is_marker  = (sym_q == MARKER_BYTE);
	assign stat.fill_zero  = (fill_q == '0);
	assign stat.fill_lt2   = (fill_q < 2);
	assign stat.ready      = ready_q;
	assign stat.at_end     = (i_q == fill_q);
	assign stat.match      = (tab_rd.sym == sym_q);
	assign stat.cmp_last   = ((i_q + 2) == fill_q);
	assign stat.pass_last  = ((pass_q + 2) == fill_q);
	assign stat.last_entry = ((i_q + 1) == fill_q);
	assign stat.live_one   = (live_q == FILL_W'(1));
	assign stat.scan_last  = ((i_q + 1) == live_q);
	assign stat.sh_none    = ((hi_q + 1) == live_q);
	assign stat.sh_last    = ((i_q + 2) == live_q);
	assign stat.out_free   = out_free;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_SYMBOLS))
		else $error("table fill beyond capacity");
	a_merge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == STP_LF_WR) |-> (lo_q != hi_q))
		else $error("merge picked the same node twice");
	a_fail_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q.status != ST_OK) |->
		(out_q.code_bits == '0 && out_q.code_length == '0))
		else $error("code returned with a failing status");
	a_code_fits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> ((out_q.code_bits >> out_q.code_length) == '0))
		else $error("code bits above code length");
`endif

endmodule
`default_nettype wire

>>> src/huffman_code_builder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_builder_unit
// counts bytes into a symbol table, builds huffman codes and answers codes
// ----------------------------------------------------------------------------
// channel | direction | fields
// s_*     | in        | tuser[1:0] opcode, tdata[7:0] symbol
// m_*     | out       | tdata: status, code_bits, code_length, distinct_symbols
//
// one item at a time; n is the table fill
// count and encode: one table ram read per entry
// build: sort (n-1) passes, then each merge scans live weights, updates all
//   leaves and shifts weights, limited by the single weight and leaf ram ports
// reset clears fill and code-ready state; stores are not cleared
// a waiting result does not block acceptance; completion waits for m_tready
// ----------------------------------------------------------------------------
module huffman_code_builder_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [hcb_pkg::IN_W-1:0]  s_tdata,  // symbol
	input  wire logic [hcb_pkg::OP_W-1:0]  s_tuser,  // opcode
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [hcb_pkg::OUT_W-1:0] m_tdata   // status, code_bits, code_length,
	                                                 // distinct_symbols, zero pad
);
	import hcb_pkg::*;

	hcb_cmd_t  cmd;
	hcb_stat_t stat;

	hcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hcb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the huffman code builder unit. It drives count,
// build, encode and unused-opcode transfers and predicts every response. The
// predictor keeps its own symbol table and builds its own code set. Responses
// are checked field by field, in order. Random stimulus runs through phases
// with and without sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import hcb_pkg::*;

	localparam int LIMIT_CYCLES = 8000000;
	localparam int N_RANDOM     = 600;

	class hcb_scoreboard;
		logic [SYM_W-1:0]       sym_tab[MAX_SYMBOLS];
		logic [COUNT_WIDTH-1:0] cnt_tab[MAX_SYMBOLS];
		logic [CODE_W-1:0]      code_tab[MAX_SYMBOLS];
		logic [LEN_W-1:0]       len_tab[MAX_SYMBOLS];
		int                     fill;
		bit                     built;
		out_pkt_t               pending[$];
		int                     errors;
		int                     checked;
		int                     status_seen[4];

		function new();
			fill = 0;
			built = 0;
			errors = 0;
			checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function status_t count_symbol(logic [SYM_W-1:0] s);
			if (s == MARKER_BYTE) return ST_OK;
			for (int i = 0; i < fill; i++) begin
				if (sym_tab[i] == s) begin
					if (cnt_tab[i] != {COUNT_WIDTH{1'b1}}) cnt_tab[i]++;
					built = 0;
					return ST_OK;
				end
			end
			if (fill >= MAX_SYMBOLS) return ST_FULL;
			sym_tab[fill] = s;
			cnt_tab[fill] = COUNT_WIDTH'(1);
			fill++;
			built = 0;
			return ST_OK;
		endfunction

		function status_t build_codes();
			logic [COUNT_WIDTH-1:0] tc;
			logic [SYM_W-1:0]       ts;
			int                     weight[MAX_SYMBOLS];
			int                     slot[MAX_SYMBOLS];
			int                     live, lo, hi;
			bit                     have_lo, have_hi;
			if (fill == 0) begin
				built = 0;
				return ST_NOT_BUILT;
			end
			for (int p = 1; p < fill; p++)
				for (int r = 0; r + p < fill; r++)
					if (cnt_tab[r] < cnt_tab[r+1]) begin
						tc = cnt_tab[r]; ts = sym_tab[r];
						cnt_tab[r] = cnt_tab[r+1]; sym_tab[r] = sym_tab[r+1];
						cnt_tab[r+1] = tc; sym_tab[r+1] = ts;
					end
			for (int i = 0; i < fill; i++) begin
				weight[i] = int'(cnt_tab[i]);
				code_tab[i] = '0;
				len_tab[i] = '0;
				slot[i] = i;
			end
			live = fill;
			while (live > 1) begin
				lo = 0; hi = 0; have_lo = 0; have_hi = 0;
				for (int i = 0; i < live; i++) begin
					if (!have_lo) begin
						lo = i; have_lo = 1;
					end else if (weight[i] < weight[lo]) begin
						hi = lo; have_hi = 1; lo = i;
					end else if (!have_hi || weight[i] < weight[hi]) begin
						hi = i; have_hi = 1;
					end
				end
				for (int i = 0; i < fill; i++)
					if (slot[i] == lo || slot[i] == hi) begin
						if (slot[i] == hi) code_tab[i] |= 63'd1 << len_tab[i];
						len_tab[i] = len_tab[i] + 1'b1;
						slot[i] = lo;
					end
				weight[lo] = weight[lo] + weight[hi];
				for (int i = hi; i + 1 < live; i++) weight[i] = weight[i+1];
				for (int i = 0; i < fill; i++)
					if (slot[i] > hi) slot[i]--;
				live--;
			end
			built = 1;
			return ST_OK;
		endfunction

		function void note_input(op_t op, logic [SYM_W-1:0] s);
			out_pkt_t e;
			e = '0;
			e.status = ST_OK;
			case (op)
				OP_COUNT: begin
					e.status = count_symbol(s);
				end
				OP_BUILD: begin
					e.status = build_codes();
				end
				OP_ENCODE: begin
					if (!built) e.status = ST_NOT_BUILT;
					else begin
						e.status = ST_UNKNOWN;
						for (int i = 0; i < fill; i++)
							if (e.status == ST_UNKNOWN && sym_tab[i] == s) begin
								e.status = ST_OK;
								e.code_bits = code_tab[i];
								e.code_length = len_tab[i];
							end
					end
				end
				default: ;
			endcase
			e.distinct_symbols = fill[DIST_W-1:0];
			pending.push_back(e);
		endfunction

		task check_result(out_pkt_t got);
			out_pkt_t e;
			if (pending.size() == 0) begin
				report("response with nothing expected");
				return;
			end
			e = pending.pop_front();
			checked++;
			status_seen[got.status]++;
			if (got.status != e.status)
				report($sformatf("status %0d, want %0d", got.status, e.status));
			if (got.code_bits != e.code_bits)
				report($sformatf("code_bits %h, want %h", got.code_bits, e.code_bits));
			if (got.code_length != e.code_length)
				report($sformatf("code_length %0d, want %0d", got.code_length,
				                 e.code_length));
			if (got.distinct_symbols != e.distinct_symbols)
				report($sformatf("distinct_symbols %0d, want %0d",
				                 got.distinct_symbols, e.distinct_symbols));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;  // symbol
	logic [OP_W-1:0]   s_tuser;  // opcode
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;  // status, code_bits, code_length, distinct_symbols

	hcb_scoreboard sb;
	int            cycles;
	int            tx_gap_pct;
	int            rx_stall_pct;
	int            op_seen[4];

	huffman_code_builder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(out_pkt_t'(m_tdata));
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	task send(op_t op, logic [SYM_W-1:0] s);
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= s;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, s);
		op_seen[op]++;
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function logic [SYM_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return MARKER_BYTE;
		if (r < 33 || sb.fill == 0) return SYM_W'($urandom_range(0, 255));
		return sb.sym_tab[$urandom_range(0, $urandom_range(0, sb.fill - 1))];
	endfunction

	initial begin
		int r;
		sb = new();
		cycles = 0;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		foreach (op_seen[i]) op_seen[i] = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_COUNT;
		m_tready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(OP_ENCODE, 8'h41);
		send(OP_BUILD, 8'h00);
		send(OP_COUNT, MARKER_BYTE);
		send(OP_NOP, 8'hFF);
		send(OP_COUNT, 8'h00);
		send(OP_BUILD, 8'hFF);
		send(OP_ENCODE, 8'h00);
		send(OP_ENCODE, MARKER_BYTE);
		send(OP_ENCODE, 8'hFF);
		send(OP_COUNT, 8'hFF);
		send(OP_ENCODE, 8'h00);
		send(OP_BUILD, 8'h00);
		send(OP_ENCODE, 8'h00);
		send(OP_ENCODE, 8'hFF);
		// repeated counts of one symbol
		for (int i = 0; i < 20; i++) send(OP_COUNT, 8'hFF);
		send(OP_COUNT, 8'h00);
		send(OP_COUNT, 8'hFF);
		send(OP_BUILD, 8'h00);
		send(OP_ENCODE, 8'hFF);
		send(OP_ENCODE, 8'h00);
		send(OP_NOP, 8'h00);
		drain();

		// random phases
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 150 == 0) begin
				drain();
				case (n / 150)
					0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
					1: begin tx_gap_pct = 50; rx_stall_pct = 0;  end
					2: begin tx_gap_pct = 0;  rx_stall_pct = 50; end
					default: begin tx_gap_pct = 16; rx_stall_pct = 16; end
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 55) send(OP_COUNT, pick_symbol());
			else if (r < 58) send(OP_BUILD, SYM_W'($urandom_range(0, 255)));
			else if (r < 97) send(OP_ENCODE, pick_symbol());
			else send(OP_NOP, SYM_W'($urandom_range(0, 255)));
		end
		drain();
		repeat (200) @(posedge clk);

		$display("ops sent: %0d count, %0d build, %0d encode, %0d unused; table fill %0d",
		         op_seen[OP_COUNT], op_seen[OP_BUILD], op_seen[OP_ENCODE], op_seen[OP_NOP],
		         sb.fill);
		$display("responses checked %0d: ok %0d, full %0d, unknown %0d, not built %0d",
		         sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
		         sb.status_seen[ST_UNKNOWN], sb.status_seen[ST_NOT_BUILT]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d responses missing", sb.errors, sb.pending.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/hcb_pkg.sv
src/hcb_ram.sv
src/hcb_ctrl.sv
src/hcb_dp.sv
src/huffman_code_builder_unit.sv
sim/tb_top.sv
